>>> hdl/xtea_block_cipher_core_defines.svh
// Assertion macros shared by the cipher core.
`ifndef XTEA_BLOCK_CIPHER_CORE_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define XBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("xtea core check failed");
`define XBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("xtea core check failed");
`else
`define XBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define XBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/xbc_pkg.sv
package xbc_pkg;

  typedef logic [31:0] word_t;
  typedef logic [1:0]  key_idx_t;

  localparam int    XBC_ROUNDS = 32;
  localparam word_t XBC_DELTA  = 32'h9E37_79B9;
  localparam int    XBC_KEYS   = 4;

  function automatic word_t mix_word(word_t v);
    word_t mixed;
    mixed = ((v << 4) ^ (v >> 5)) + v;
    return mixed;
  endfunction

  // Key schedule sum after n rounds, modulo 2^32.
  function automatic word_t sum_at(int n);
    word_t cnt;
    word_t prod;
    cnt  = 32'(n);
    prod = cnt * XBC_DELTA;
    return prod;
  endfunction

endpackage

>>> hdl/xtea_block_cipher_core.sv
// XTEA block cipher core, 64-bit block, 128-bit key.
// Input: an item (in_req_type, in_data_left, in_data_right) is taken at each
// rising edge where start is high and busy is low. Busy is high during reset
// and until the first clock edge with rst_n high, then one item may be issued on
// every clock.
// Key: four 32-bit words written through cfg_valid/cfg_ready with cfg_index
// selecting the word. cfg_ready is always high. The user must change keys only
// while no item is in flight; the core itself does not enforce this.
// Output: out_valid is high for exactly one cycle with out_left/out_right.
// Pipeline: an item is held in an input register, then moves through one
// register stage per half-cycle of the cipher, each of one mix add and one
// keyed add/subtract, to the last stage, which drives the outputs. Throughput is
// one item per clock, since every half-cycle has its own register stage.
// The receiver cannot stall; results are presented in issue order.
// Reset: synchronous and active low, it clears all valid bits and the key.
`include "xtea_block_cipher_core_defines.svh"

module xtea_block_cipher_core #(
  parameter int ROUNDS = xbc_pkg::XBC_ROUNDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  xbc_pkg::word_t     in_data_left,
  input  xbc_pkg::word_t     in_data_right,
  output logic               out_valid,
  output xbc_pkg::word_t     out_left,
  output xbc_pkg::word_t     out_right,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  xbc_pkg::key_idx_t  cfg_index,
  input  xbc_pkg::word_t     cfg_wdata
);
  import xbc_pkg::*;

  localparam int STAGES = 2 * ROUNDS;
  localparam int LAT    = STAGES + 1;

  logic  busy_r;
  logic  accept;
  word_t key_r [XBC_KEYS];

  logic  vld_r [STAGES+1];
  logic  op_r  [STAGES+1];
  word_t v0_r  [STAGES+1];
  word_t v1_r  [STAGES+1];
  word_t v0_nxt [STAGES+1];
  word_t v1_nxt [STAGES+1];

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      for (int i = 0; i < XBC_KEYS; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        key_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  assign v0_nxt[0] = in_data_left;
  assign v1_nxt[0] = in_data_right;

  genvar k;
  generate
    for (k = 0; k < STAGES; k++) begin : g_stage
      localparam int       RI    = k / 2;
      localparam bit       EVEN  = ((k % 2) == 0);
      localparam word_t    SUM_E = EVEN ? sum_at(RI) : sum_at(RI + 1);
      localparam word_t    SUM_D = EVEN ? sum_at(ROUNDS - RI) : sum_at(ROUNDS - RI - 1);
      localparam key_idx_t KI_E  = EVEN ? SUM_E[1:0] : SUM_E[12:11];
      localparam key_idx_t KI_D  = EVEN ? SUM_D[12:11] : SUM_D[1:0];

      word_t src;
      word_t sk;
      word_t f;

      assign src = (op_r[k] ^ EVEN) ? v1_r[k] : v0_r[k];
      assign sk  = op_r[k] ? (SUM_D + key_r[KI_D]) : (SUM_E + key_r[KI_E]);
      assign f   = mix_word(src) ^ sk;

      if (EVEN) begin : g_even
        assign v0_nxt[k+1] = op_r[k] ? v0_r[k] : v0_r[k] + f;
        assign v1_nxt[k+1] = op_r[k] ? v1_r[k] - f : v1_r[k];
      end else begin : g_odd
        assign v0_nxt[k+1] = op_r[k] ? v0_r[k] - f : v0_r[k];
        assign v1_nxt[k+1] = op_r[k] ? v1_r[k] : v1_r[k] + f;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i <= STAGES; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r[0] <= in_req_type;
    for (int i = 1; i <= STAGES; i++) begin
      op_r[i] <= op_r[i-1];
    end
    for (int i = 0; i <= STAGES; i++) begin
      v0_r[i] <= v0_nxt[i];
      v1_r[i] <= v1_nxt[i];
    end
  end

  assign out_valid = vld_r[STAGES];
  assign out_left  = v0_r[STAGES];
  assign out_right = v1_r[STAGES];

  `XBC_ASSERT_NOW(a_out_from_accept, clk, rst_n, out_valid, $past(accept, LAT))
  `XBC_ASSERT_NOW(a_op_travels, clk, rst_n, out_valid, op_r[STAGES] == $past(in_req_type, LAT))
  `XBC_ASSERT_NEXT(a_busy_clear, clk, rst_n, rst_n, !busy)

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import xbc_pkg::*;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  localparam key_idx_t KEY_WORD_0 = 2'd0;
  localparam key_idx_t KEY_WORD_1 = 2'd1;
  localparam key_idx_t KEY_WORD_2 = 2'd2;
  localparam key_idx_t KEY_WORD_3 = 2'd3;

  localparam int RESULT_LATENCY  = 2 * XBC_ROUNDS;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 90;

  typedef struct packed {
    word_t left;
    word_t right;
  } block_t;

  class cipher_block_board;
    word_t  key_words[XBC_KEYS];
    block_t expected_blocks[$];
    int     mismatches;
    int     compared;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      mismatches = 0;
      compared   = 0;
    endfunction

    function void set_key(key_idx_t idx, word_t value);
      key_words[idx] = value;
    endfunction

    function word_t feistel_mix(word_t v);
      return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function block_t encipher_block(block_t blk);
      word_t v0;
      word_t v1;
      word_t sum;
      v0  = blk.left;
      v1  = blk.right;
      sum = '0;
      for (int i = 0; i < XBC_ROUNDS; i++) begin
        v0  = v0 + (feistel_mix(v1) ^ (sum + key_words[sum[1:0]]));
        sum = sum + XBC_DELTA;
        v1  = v1 + (feistel_mix(v0) ^ (sum + key_words[sum[12:11]]));
      end
      return '{left: v0, right: v1};
    endfunction

    function block_t decipher_block(block_t blk);
      word_t v0;
      word_t v1;
      word_t sum;
      v0  = blk.left;
      v1  = blk.right;
      sum = XBC_DELTA * word_t'(XBC_ROUNDS);
      for (int i = 0; i < XBC_ROUNDS; i++) begin
        v1  = v1 - (feistel_mix(v0) ^ (sum + key_words[sum[12:11]]));
        sum = sum - XBC_DELTA;
        v0  = v0 - (feistel_mix(v1) ^ (sum + key_words[sum[1:0]]));
      end
      return '{left: v0, right: v1};
    endfunction

    function void note_block(logic req, word_t left, word_t right);
      block_t blk;
      blk = '{left: left, right: right};
      if (req == REQ_DECRYPT) begin
        expected_blocks.push_back(decipher_block(blk));
      end else begin
        expected_blocks.push_back(encipher_block(blk));
      end
    endfunction

    function void check_block(word_t left, word_t right);
      block_t want;
      if (expected_blocks.size() == 0) begin
        $error("result %h %h arrived with no block outstanding", left, right);
        mismatches++;
        return;
      end
      want = expected_blocks.pop_front();
      compared++;
      if (left !== want.left) begin
        $error("out_left: expected %h, actual %h", want.left, left);
        mismatches++;
      end
      if (right !== want.right) begin
        $error("out_right: expected %h, actual %h", want.right, right);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic     clk           = 1'b0;
  logic     rst_n         = 1'b0;
  logic     start         = 1'b0;
  logic     busy;
  logic     in_req_type   = REQ_ENCRYPT;
  word_t    in_data_left  = '0;
  word_t    in_data_right = '0;
  logic     out_valid;
  word_t    out_left;
  word_t    out_right;
  logic     cfg_valid     = 1'b0;
  logic     cfg_ready;
  key_idx_t cfg_index     = KEY_WORD_0;
  word_t    cfg_wdata     = '0;

  cipher_block_board board;
  int encrypts  = 0;
  int decrypts  = 0;
  int key_loads = 0;

  xtea_block_cipher_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_data_left (in_data_left),
    .in_data_right(in_data_right),
    .out_valid    (out_valid),
    .out_left     (out_left),
    .out_right    (out_right),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_block(out_left, out_right);
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    word_t    words[XBC_KEYS];
    key_idx_t idx[XBC_KEYS];
    words = '{k0, k1, k2, k3};
    idx   = '{KEY_WORD_0, KEY_WORD_1, KEY_WORD_2, KEY_WORD_3};
    cfg_valid <= 1'b1;
    for (int i = 0; i < XBC_KEYS; i++) begin
      cfg_index <= idx[i];
      cfg_wdata <= words[i];
      do @(posedge clk); while (!cfg_ready);
      board.set_key(idx[i], words[i]);
    end
    cfg_valid <= 1'b0;
    key_loads++;
  endtask

  task automatic send_block(logic req, word_t left, word_t right, bit idle_ok);
    if (idle_ok) begin
      while ($urandom_range(99) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_data_left  <= left;
    in_data_right <= right;
    do @(posedge clk); while (busy);
    board.note_block(req, left, right);
    if (req == REQ_DECRYPT) begin
      decrypts++;
    end else begin
      encrypts++;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic directed_blocks();
    block_t blk;
    send_block(REQ_ENCRYPT, '0, '0, 1'b1);
    send_block(REQ_ENCRYPT, '1, '1, 1'b1);
    send_block(REQ_DECRYPT, '0, '0, 1'b1);
    send_block(REQ_DECRYPT, '1, '1, 1'b1);
    send_block(REQ_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    blk = board.encipher_block('{left: 32'h0123_4567, right: 32'h89AB_CDEF});
    send_block(REQ_DECRYPT, blk.left, blk.right, 1'b1);
    drain_results();
  endtask

  initial begin
    block_t blk;
    logic   req;
    bit     idle_ok;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The key is still all zero after reset.
    directed_blocks();
    load_key('1, '1, '1, '1);
    directed_blocks();
    load_key('0, '1, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    directed_blocks();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      case (p)
        1: load_key('1, '1, '1, '1);
        4: load_key('0, '0, '0, '0);
        default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
      endcase
      idle_ok = (p != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        if ($urandom_range(4) == 0) begin
          blk = board.encipher_block('{left: pick_word(), right: pick_word()});
          send_block(REQ_DECRYPT, blk.left, blk.right, idle_ok);
        end else begin
          req = 1'($urandom_range(1));
          send_block(req, pick_word(), pick_word(), idle_ok);
        end
      end
    end

    drain_results();
    repeat (RESULT_LATENCY + 8) @(posedge clk);

    $display("Sent %0d encrypt and %0d decrypt items across %0d key settings.",
             encrypts, decrypts, key_loads);
    $display("Compared %0d result blocks, %0d mismatches.", board.compared,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/xbc_pkg.sv
hdl/xtea_block_cipher_core.sv
dv/tb_top.sv
